// ===== rtl/fcc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the fan curve controller.
package fcc_pkg;

	localparam int BAND_COUNT_DEF = 8;
	localparam int MAX_BANDS      = 8;

	localparam int PCT_W   = 7;
	localparam int CODE_W  = 8;
	localparam int TEMP_W  = 19;
	localparam int TIME_W  = 32;
	localparam int DEG_W   = 8;
	localparam int HYS_W   = 6;
	localparam int DWELL_W = 16;
	localparam int THR_W   = 64;
	localparam int DUTY_W  = 56;
	localparam int MILLI_W = 20;

	localparam int APB_DW = 64;
	localparam int APB_AW = 6;
	localparam int REG_W  = 3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// register map indexes (byte address = 8 * index)
	localparam logic [REG_W-1:0] REG_EMERG  = 3'd0;
	localparam logic [REG_W-1:0] REG_HYST   = 3'd1;
	localparam logic [REG_W-1:0] REG_DWELL  = 3'd2;
	localparam logic [REG_W-1:0] REG_STEP   = 3'd3;
	localparam logic [REG_W-1:0] REG_THRESH = 3'd4;
	localparam logic [REG_W-1:0] REG_DUTIES = 3'd5;

	localparam logic [DEG_W-1:0]   EMERG_RST  = 8'd80;
	localparam logic [HYS_W-1:0]   HYST_RST   = 6'd3;
	localparam logic [DWELL_W-1:0] DWELL_RST  = 16'd20;
	localparam logic [PCT_W-1:0]   STEP_RST   = 7'd8;
	localparam logic [THR_W-1:0]   THRESH_RST = 64'hFF46413C37322D00;
	localparam logic [DUTY_W-1:0]  DUTIES_RST = 56'd56693412709498880;

	localparam logic [PCT_W-1:0]  PCT_ZERO  = 7'd0;
	localparam logic [PCT_W-1:0]  PCT_FULL  = 7'd100;
	localparam logic [PCT_W-1:0]  STEP_MIN  = 7'd2;
	localparam logic [CODE_W-1:0] CODE_FULL = 8'd255;

	typedef struct packed {
		logic [DEG_W-1:0]   alarm_deg;
		logic [HYS_W-1:0]   hysteresis_deg;
		logic [DWELL_W-1:0] min_dwell_seconds;
		logic [PCT_W-1:0]   step_size;
		logic [THR_W-1:0]   band_thresholds;
		logic [DUTY_W-1:0]  band_duties;
	} cfg_t;

	// one ramp command: walk from start_pct to end_pct
	typedef struct packed {
		logic [PCT_W-1:0] start_pct;
		logic [PCT_W-1:0] end_pct;
		logic             emergency;
	} cmd_t;

	// degrees (signed) to millidegrees
	function automatic logic signed [MILLI_W-1:0] deg_to_milli(input logic signed [9:0] deg);
		logic signed [29:0] prod;
		prod = 30'(deg) * 30'sd1000;
		return prod[MILLI_W-1:0];
	endfunction

	function automatic logic [PCT_W-1:0] clamp_duty(input logic [PCT_W-1:0] d);
		return (d > PCT_FULL) ? PCT_FULL : d;
	endfunction

	// floor(pct*255/100): 255/100 folded into 1336965 / 2^19, exact for pct 0..100
	function automatic logic [CODE_W-1:0] pct_to_code(input logic [PCT_W-1:0] pct);
		logic [27:0] prod;
		prod = 28'(pct) * 28'd1336965;
		return prod[26:19];
	endfunction

endpackage

// ===== rtl/fcc_front.sv =====
// Front end: takes a sample request, resolves the target duty and queues a ramp command.
module fcc_front #(
	parameter int BAND_COUNT = fcc_pkg::BAND_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  logic [fcc_pkg::TEMP_W-1:0]  temp_milli,
	input  logic [fcc_pkg::TIME_W-1:0]  now_seconds,
	input  fcc_pkg::cfg_t               cfg,
	input  logic                        full,
	output logic                        push,
	output fcc_pkg::cmd_t               push_cmd
);
	import fcc_pkg::*;

	localparam int IDX_W = $clog2(BAND_COUNT);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EMERG = 3'd1;
	localparam logic [2:0] ST_BASE  = 3'd2;
	localparam logic [2:0] ST_CMP   = 3'd3;
	localparam logic [2:0] ST_HYS   = 3'd4;
	localparam logic [2:0] ST_HCMP  = 3'd5;
	localparam logic [2:0] ST_DWELL = 3'd6;

	logic [2:0]                state_q;
	logic [IDX_W-1:0]          idx_q;
	logic [PCT_W-1:0]          level_q;
	logic [TIME_W-1:0]         last_change_q;
	logic signed [TEMP_W-1:0]  temp_q;
	logic [TIME_W-1:0]         now_q;
	logic                      emerg_q;
	logic [PCT_W-1:0]          base_q;
	logic [DEG_W-1:0]          hthr_q;
	logic [PCT_W-1:0]          target_q;

	logic [DEG_W-1:0]          thr_arr [BAND_COUNT];
	logic [PCT_W-1:0]          duty_arr [BAND_COUNT];
	logic signed [MILLI_W-1:0] temp_w;
	logic signed [MILLI_W-1:0] band_milli;
	logic signed [MILLI_W-1:0] emerg_milli;
	logic signed [MILLI_W-1:0] hys_milli;
	logic signed [9:0]         hys_deg;
	logic                      idx_last;
	logic [TIME_W-1:0]         elapsed;
	logic                      refuse;
	logic                      change;

	always_comb begin
		for (int i = 0; i < BAND_COUNT; i++) begin
			thr_arr[i]  = cfg.band_thresholds[8*i +: 8];
			duty_arr[i] = clamp_duty(cfg.band_duties[7*i +: 7]);
		end
	end

	assign temp_w      = MILLI_W'(temp_q);
	assign band_milli  = deg_to_milli($signed({2'b00, thr_arr[idx_q]}));
	assign emerg_milli = deg_to_milli($signed({2'b00, cfg.alarm_deg}));
	assign hys_deg     = $signed({2'b00, hthr_q}) - $signed({4'b0000, cfg.hysteresis_deg});
	assign hys_milli   = deg_to_milli(hys_deg);
	assign idx_last    = (idx_q == IDX_W'(BAND_COUNT - 1));

	// dwell check, wraps modulo 2^32
	assign elapsed = now_q - last_change_q;
	assign refuse  = (elapsed < {16'b0, cfg.min_dwell_seconds});
	assign change  = (target_q != level_q) && !refuse;

	assign sample_stall       = (state_q != ST_IDLE);
	assign push               = (state_q == ST_DWELL) && !full;
	assign push_cmd.start_pct = level_q;
	assign push_cmd.end_pct   = change ? target_q : level_q;
	assign push_cmd.emergency = emerg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			idx_q         <= '0;
			level_q       <= PCT_ZERO;
			last_change_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (sample_valid) state_q <= ST_EMERG;
				end
				ST_EMERG: begin
					idx_q   <= '0;
					state_q <= (temp_w >= emerg_milli) ? ST_DWELL : ST_BASE;
				end
				ST_BASE: begin
					if (temp_w <= band_milli || idx_last) begin
						state_q <= ST_CMP;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_CMP: begin
					idx_q   <= '0;
					state_q <= (base_q < level_q) ? ST_HYS : ST_DWELL;
				end
				ST_HYS: begin
					if (duty_arr[idx_q] == base_q || idx_last) begin
						state_q <= ST_HCMP;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_HCMP: begin
					state_q <= ST_DWELL;
				end
				ST_DWELL: begin
					if (!full) begin
						if (change) begin
							level_q       <= target_q;
							last_change_q <= now_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					temp_q <= $signed(temp_milli);
					now_q  <= now_seconds;
				end
			end
			ST_EMERG: begin
				emerg_q  <= (temp_w >= emerg_milli);
				target_q <= PCT_FULL;
			end
			ST_BASE: begin
				if (temp_w <= band_milli) begin
					base_q <= duty_arr[idx_q];
				end else if (idx_last) begin
					base_q <= PCT_FULL;
				end
			end
			ST_CMP: begin
				hthr_q   <= '0;
				target_q <= (base_q > level_q) ? base_q : level_q;
			end
			ST_HYS: begin
				if (duty_arr[idx_q] == base_q) hthr_q <= thr_arr[idx_q];
			end
			ST_HCMP: begin
				target_q <= (temp_w > hys_milli) ? level_q : base_q;
			end
			ST_DWELL: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/fcc_queue.sv =====
// Small command FIFO between the front end and the ramp engine.
module fcc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fcc_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output fcc_pkg::cmd_t head,
	output logic          empty
);
	import fcc_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ===== rtl/fcc_back.sv =====
// Ramp engine: walks each command in clamped steps into the result register.
module fcc_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [fcc_pkg::PCT_W-1:0]  step_size,
	input  fcc_pkg::cmd_t              head,
	input  logic                       empty,
	output logic                       pop,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [fcc_pkg::PCT_W-1:0]  duty_percent,
	output logic [fcc_pkg::CODE_W-1:0] duty_code,
	output logic                       emergency,
	output logic                       last
);
	import fcc_pkg::*;

	logic              busy_q;
	logic              out_valid_q;
	logic [PCT_W-1:0]  pct_q;
	logic [PCT_W-1:0]  tgt_q;
	logic              emerg_run_q;
	logic [PCT_W-1:0]  out_pct_q;
	logic [CODE_W-1:0] out_code_q;
	logic              out_emerg_q;
	logic              out_last_q;

	logic              slot_free;
	logic [PCT_W-1:0]  step;
	logic [PCT_W-1:0]  pct_nxt;

	assign slot_free = !out_valid_q || !result_stall;
	assign step      = (step_size < STEP_MIN) ? STEP_MIN : step_size;
	assign pop       = !busy_q && !empty && slot_free;

	always_comb begin
		if (tgt_q > pct_q) begin
			pct_nxt = ((tgt_q - pct_q) > step) ? pct_q + step : tgt_q;
		end else begin
			pct_nxt = ((pct_q - tgt_q) > step) ? pct_q - step : tgt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			if (busy_q) begin
				out_valid_q <= 1'b1;
				if (pct_nxt == tgt_q) busy_q <= 1'b0;
			end else if (pop) begin
				// no change: one result right away, else start walking
				out_valid_q <= (head.start_pct == head.end_pct);
				busy_q      <= (head.start_pct != head.end_pct);
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (busy_q) begin
				pct_q       <= pct_nxt;
				out_pct_q   <= pct_nxt;
				out_code_q  <= pct_to_code(pct_nxt);
				out_emerg_q <= emerg_run_q;
				out_last_q  <= (pct_nxt == tgt_q);
			end else if (pop) begin
				pct_q       <= head.start_pct;
				tgt_q       <= head.end_pct;
				emerg_run_q <= head.emergency;
				out_pct_q   <= head.start_pct;
				out_code_q  <= pct_to_code(head.start_pct);
				out_emerg_q <= head.emergency;
				out_last_q  <= 1'b1;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign duty_percent = out_pct_q;
	assign duty_code    = out_code_q;
	assign emergency    = out_emerg_q;
	assign last         = out_last_q;

endmodule

// ===== rtl/fan_curve_controller.sv =====
// Fan curve controller top level: register file, front end, command queue, ramp engine.
// A sample request passes the front end through the emergency check, then, below the alarm,
//   the band scan, a compare and, when the duty would fall, the hysteresis scan, then is queued.
// The front end takes no new request until the last one's command is queued; results leave
//   one per cycle along a ramp while result_stall is low, with a gap before each ramp.
// Reset (arst_n low): level 0%, last change time 0, registers to defaults, queue empty.
module fan_curve_controller #(
	parameter int BAND_COUNT = fcc_pkg::BAND_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// sample request channel
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  logic [fcc_pkg::TEMP_W-1:0]  temp_milli,
	input  logic [fcc_pkg::TIME_W-1:0]  now_seconds,
	// result channel
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [fcc_pkg::PCT_W-1:0]   duty_percent,
	output logic [fcc_pkg::CODE_W-1:0]  duty_code,
	output logic                        emergency,
	output logic                        last,
	// register port, 64-bit registers at 8-byte spacing
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fcc_pkg::APB_AW-1:0]  paddr,
	input  logic [fcc_pkg::APB_DW-1:0]  pwdata,
	output logic [fcc_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import fcc_pkg::*;

	cfg_t             cfg_q;
	logic [REG_W-1:0] reg_idx;
	logic             wr_en;

	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	cmd_t             q_in;
	cmd_t             q_head;

	// ------------------------------------------------------------------
	// Register file. Writes land on the access phase; pready is tied high
	// so every transfer is zero wait-state. Indexes past the map are dropped.
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:3];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alarm_deg         <= EMERG_RST;
			cfg_q.hysteresis_deg    <= HYST_RST;
			cfg_q.min_dwell_seconds <= DWELL_RST;
			cfg_q.step_size         <= STEP_RST;
			cfg_q.band_thresholds   <= THRESH_RST;
			cfg_q.band_duties       <= DUTIES_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_EMERG:  cfg_q.alarm_deg         <= pwdata[DEG_W-1:0];
				REG_HYST:   cfg_q.hysteresis_deg    <= pwdata[HYS_W-1:0];
				REG_DWELL:  cfg_q.min_dwell_seconds <= pwdata[DWELL_W-1:0];
				REG_STEP:   cfg_q.step_size         <= pwdata[PCT_W-1:0];
				REG_THRESH: cfg_q.band_thresholds   <= pwdata[THR_W-1:0];
				REG_DUTIES: cfg_q.band_duties       <= pwdata[DUTY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_EMERG:  prdata = APB_DW'(cfg_q.alarm_deg);
			REG_HYST:   prdata = APB_DW'(cfg_q.hysteresis_deg);
			REG_DWELL:  prdata = APB_DW'(cfg_q.min_dwell_seconds);
			REG_STEP:   prdata = APB_DW'(cfg_q.step_size);
			REG_THRESH: prdata = APB_DW'(cfg_q.band_thresholds);
			REG_DUTIES: prdata = APB_DW'(cfg_q.band_duties);
			default:    prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Front end: owns the controller state (current level, last change
	// time) and commits it when the command is queued, so the next
	// request can be classified while the ramp is still being emitted.
	// ------------------------------------------------------------------
	fcc_front #(
		.BAND_COUNT (BAND_COUNT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.temp_milli   (temp_milli),
		.now_seconds  (now_seconds),
		.cfg          (cfg_q),
		.full         (q_full),
		.push         (q_push),
		.push_cmd     (q_in)
	);

	// decouples classification from a ramp that may take up to 50 results
	fcc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	// Ramp engine with registered result; holds under result_stall.
	fcc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_size    (cfg_q.step_size),
		.head         (q_head),
		.empty        (q_empty),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.duty_percent (duty_percent),
		.duty_code    (duty_code),
		.emergency    (emergency),
		.last         (last)
	);

endmodule

// ===== rtl/fcc_checker.sv =====
// Port-level checks for the fan curve controller, bound to the top level.
module fcc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        result_valid,
	input logic                        result_stall,
	input logic [fcc_pkg::PCT_W-1:0]   duty_percent,
	input logic [fcc_pkg::CODE_W-1:0]  duty_code,
	input logic                        emergency,
	input logic                        last,
	input logic                        pready
);
	import fcc_pkg::*;

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid &&
		$stable({duty_percent, duty_code, emergency, last}))
		else $error("result changed while stalled");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> duty_percent <= PCT_FULL)
		else $error("duty percent above full scale");

	a_code_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (duty_percent != PCT_FULL || duty_code == CODE_FULL) &&
		(duty_percent != PCT_ZERO || duty_code == '0))
		else $error("duty code does not match percent at end points");

	a_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("register port inserted a wait state");

endmodule

bind fan_curve_controller fcc_checker u_fcc_checker (.*);
